// ===== design/aards_pkg.sv =====
// Shared types and constants for the area-averaging RGB downscaler.
package aards_pkg;

    localparam int CFG_W = 9;
    localparam int IDX_W = 2;
    localparam int CH_W = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int SUM_W = 11;
    localparam int SAMPLE_LIMIT = 5;

    // reciprocal of SAMPLE_LIMIT: (v * DIV5_MUL) >> DIV5_SHIFT equals v / 5 for v < 1024
    localparam int DIV5_MUL = 205;
    localparam int DIV5_SHIFT = 10;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [IDX_W-1:0] REG_SRC_W = 2'd0;
    localparam logic [IDX_W-1:0] REG_SRC_H = 2'd1;
    localparam logic [IDX_W-1:0] REG_DST_W = 2'd2;
    localparam logic [IDX_W-1:0] REG_DST_H = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/aards_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module aards_div import aards_pkg::*; #(
    parameter int NW = 18,
    parameter int DW = 9
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output div_stat_t     stat,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;
    assign rem       = rem_reg;

endmodule

// ===== design/area_average_rgb_downscale.sv =====
// Area-averaging RGB888 downscaler: frame store plus per-pixel averaging sequencer.
//
// Input stream (s_*): tuser is the command, 0 loads the next source pixel in raster
// order, 1 reads the next destination pixel. A load gives no result. A read gives
// one result on m_*: the averaged pixel, tlast on the last pixel of the destination
// frame, tuser set (with zero data) when no complete source frame is loaded.
// Reads wrap to the first pixel after the last one.
// A read samples up to 5 source rows by 5 columns; every row and column index and
// every average runs through one shared bit-serial divider of NW = max(2*UW, 11)
// bits, so the block takes no new item until a read is through.
// Configuration writes (cfg_*) are taken while the block is idle; each one and
// reset restart the gcd-based derivation of the scale units, during which s_tready
// stays low, and discard the loaded frame.
// A finished result waits in the output register while the next item is taken;
// a stalled receiver only holds back the end of the following read.
module area_average_rgb_downscale import aards_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [PIX_W-1:0] s_tdata,   // in_red, in_green, in_blue
    input  logic             s_tuser,   // cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [PIX_W-1:0] m_tdata,   // out_red, out_green, out_blue
    output logic             m_tlast,
    output logic             m_tuser    // status
);

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);
    localparam int UW0   = (CW > RW) ? CW : RW;
    localparam int UW    = (UW0 > 3) ? UW0 : 3;
    localparam int NW    = (2 * UW > SUM_W) ? 2 * UW : SUM_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [4:0] {
        ST_CFG_START, ST_GCD, ST_GCD_WAIT, ST_UDIV, ST_UDIV_WAIT, ST_IDLE,
        ST_MUL, ST_ROW, ST_ROW_WAIT, ST_COL, ST_COL_WAIT, ST_MEM, ST_ACC,
        ST_HAVG, ST_HAVG_WAIT, ST_VAVG, ST_VAVG_WAIT, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        U_HSRC, U_HTGT, U_VSRC, U_VTGT
    } ustep_t;

    state_t state_reg;
    ustep_t ustep_reg;

    logic [CFG_W-1:0] sw_cfg_reg, sh_cfg_reg, dw_cfg_reg, dh_cfg_reg;
    logic [CW-1:0]    sw_eff, dw_eff;
    logic [RW-1:0]    sh_eff, dh_eff;

    logic [UW-1:0] ga_reg, gb_reg, g_reg;
    logic [CW-1:0] hsu_reg, htu_reg, hs_reg;
    logic [RW-1:0] vsu_reg, vtu_reg, vs_reg;
    logic [2:0]    hn, vn;

    logic [CW-1:0] lc_reg, x_reg, col_sel;
    logic [RW-1:0] lr_reg, y_reg, row_reg;
    logic          frame_ready_reg;

    logic [NW-1:0]    base_h_reg, base_v_reg, offh_reg, offv_reg;
    logic [2:0]       kh_reg, kv_reg;
    logic [1:0]       ch_reg;
    logic [SUM_W-1:0] hsum_reg [3];
    logic [SUM_W-1:0] vsum_reg [3];
    logic [CH_W-1:0]  res_reg [3];
    logic             res_last_reg, res_status_reg;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;
    logic [AW-1:0]    rd_addr_reg, wr_addr;
    logic             mem_we;

    logic             m_tvalid_reg, m_tlast_reg, m_tuser_reg;
    logic [PIX_W-1:0] m_tdata_reg;

    logic          div_start;
    logic [NW-1:0] div_num, div_quot;
    logic [UW-1:0] div_den, div_rem;
    div_stat_t     div_stat;

    // Clamp sizes: zero acts as one, oversize acts as the maximum.
    always_comb begin
        sw_eff = (sw_cfg_reg == '0) ? CW'(1) :
                 (int'(sw_cfg_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(sw_cfg_reg);
        dw_eff = (dw_cfg_reg == '0) ? CW'(1) :
                 (int'(dw_cfg_reg) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(dw_cfg_reg);
        sh_eff = (sh_cfg_reg == '0) ? RW'(1) :
                 (int'(sh_cfg_reg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(sh_cfg_reg);
        dh_eff = (dh_cfg_reg == '0) ? RW'(1) :
                 (int'(dh_cfg_reg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(dh_cfg_reg);
        hn = (int'(htu_reg) > SAMPLE_LIMIT) ? 3'(SAMPLE_LIMIT) : 3'(htu_reg);
        vn = (int'(vtu_reg) > SAMPLE_LIMIT) ? 3'(SAMPLE_LIMIT) : 3'(vtu_reg);
    end

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign mem_we    = s_tvalid && s_tready && (s_tuser == CMD_LOAD);
    assign wr_addr   = AW'(lr_reg) * AW'(MAX_WIDTH) + AW'(lc_reg);
    assign col_sel   = (div_quot >= NW'(sw_eff)) ? sw_eff - CW'(1) : CW'(div_quot);

    // Divider operand selection; operands are latched by the divider at start.
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = UW'(1);
        unique case (state_reg)
            ST_GCD: begin
                div_start = (gb_reg != '0);
                div_num   = NW'(ga_reg);
                div_den   = gb_reg;
            end
            ST_UDIV: begin
                div_start = 1'b1;
                div_den   = g_reg;
                unique case (ustep_reg)
                    U_HSRC: div_num = NW'(dw_eff);
                    U_HTGT: div_num = NW'(sw_eff);
                    U_VSRC: div_num = NW'(dh_eff);
                    U_VTGT: div_num = NW'(sh_eff);
                endcase
            end
            ST_ROW: begin
                div_start = 1'b1;
                div_num   = base_v_reg + offv_reg;
                div_den   = UW'(vsu_reg);
            end
            ST_COL: begin
                div_start = 1'b1;
                div_num   = base_h_reg + offh_reg;
                div_den   = UW'(hsu_reg);
            end
            ST_HAVG: begin
                div_start = 1'b1;
                div_num   = NW'(hsum_reg[ch_reg]);
                div_den   = UW'(hn);
            end
            ST_VAVG: begin
                div_start = 1'b1;
                div_num   = NW'(vsum_reg[ch_reg]);
                div_den   = UW'(vn);
            end
            default: div_start = 1'b0;
        endcase
    end

    aards_div #(.NW(NW), .DW(UW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= s_tdata;
        end
        rdata_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CFG_START;
            ustep_reg       <= U_HSRC;
            sw_cfg_reg      <= CFG_W'(256);
            sh_cfg_reg      <= CFG_W'(256);
            dw_cfg_reg      <= CFG_W'(128);
            dh_cfg_reg      <= CFG_W'(128);
            lc_reg          <= '0;
            lr_reg          <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            frame_ready_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            // drop the result once taken, unless the output stage reloads it
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CFG_START: begin
                    ga_reg    <= UW'(sw_eff);
                    gb_reg    <= UW'(dw_eff);
                    ustep_reg <= U_HSRC;
                    state_reg <= ST_GCD;
                end
                ST_GCD: begin
                    if (gb_reg == '0) begin
                        g_reg     <= ga_reg;
                        state_reg <= ST_UDIV;
                    end else begin
                        state_reg <= ST_GCD_WAIT;
                    end
                end
                ST_GCD_WAIT: begin
                    if (div_stat.done) begin
                        ga_reg    <= gb_reg;
                        gb_reg    <= div_rem;
                        state_reg <= ST_GCD;
                    end
                end
                ST_UDIV: state_reg <= ST_UDIV_WAIT;
                ST_UDIV_WAIT: begin
                    if (div_stat.done) begin
                        unique case (ustep_reg)
                            U_HSRC: begin
                                hsu_reg   <= CW'(div_quot);
                                ustep_reg <= U_HTGT;
                                state_reg <= ST_UDIV;
                            end
                            U_HTGT: begin
                                htu_reg <= CW'(div_quot);
                                // stride is the unit over the sample limit
                                hs_reg  <= (div_quot > NW'(SAMPLE_LIMIT)) ?
                                           CW'((32'(div_quot) * DIV5_MUL) >> DIV5_SHIFT) :
                                           CW'(1);
                                ga_reg    <= UW'(sh_eff);
                                gb_reg    <= UW'(dh_eff);
                                ustep_reg <= U_VSRC;
                                state_reg <= ST_GCD;
                            end
                            U_VSRC: begin
                                vsu_reg   <= RW'(div_quot);
                                ustep_reg <= U_VTGT;
                                state_reg <= ST_UDIV;
                            end
                            U_VTGT: begin
                                vtu_reg <= RW'(div_quot);
                                vs_reg  <= (div_quot > NW'(SAMPLE_LIMIT)) ?
                                           RW'((32'(div_quot) * DIV5_MUL) >> DIV5_SHIFT) :
                                           RW'(1);
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_IDLE: begin
                    if (cfg_valid) begin
                        unique case (cfg_index)
                            REG_SRC_W: sw_cfg_reg <= cfg_data;
                            REG_SRC_H: sh_cfg_reg <= cfg_data;
                            REG_DST_W: dw_cfg_reg <= cfg_data;
                            REG_DST_H: dh_cfg_reg <= cfg_data;
                            default:   dh_cfg_reg <= cfg_data;
                        endcase
                        lc_reg          <= '0;
                        lr_reg          <= '0;
                        x_reg           <= '0;
                        y_reg           <= '0;
                        frame_ready_reg <= 1'b0;
                        state_reg       <= ST_CFG_START;
                    end else if (s_tvalid) begin
                        if (s_tuser == CMD_LOAD) begin
                            x_reg           <= '0;
                            y_reg           <= '0;
                            frame_ready_reg <= 1'b0;
                            if (int'(lc_reg) + 1 >= int'(sw_eff)) begin
                                lc_reg <= '0;
                                if (int'(lr_reg) + 1 >= int'(sh_eff)) begin
                                    lr_reg          <= '0;
                                    frame_ready_reg <= 1'b1;
                                end else begin
                                    lr_reg <= lr_reg + RW'(1);
                                end
                            end else begin
                                lc_reg <= lc_reg + CW'(1);
                            end
                        end else if (!frame_ready_reg) begin
                            res_reg[0]     <= '0;
                            res_reg[1]     <= '0;
                            res_reg[2]     <= '0;
                            res_last_reg   <= 1'b0;
                            res_status_reg <= 1'b1;
                            state_reg      <= ST_OUT;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    base_h_reg  <= NW'(x_reg) * NW'(htu_reg);
                    base_v_reg  <= NW'(y_reg) * NW'(vtu_reg);
                    offv_reg    <= '0;
                    kv_reg      <= '0;
                    vsum_reg[0] <= '0;
                    vsum_reg[1] <= '0;
                    vsum_reg[2] <= '0;
                    state_reg   <= ST_ROW;
                end
                ST_ROW: state_reg <= ST_ROW_WAIT;
                ST_ROW_WAIT: begin
                    if (div_stat.done) begin
                        row_reg <= (div_quot >= NW'(sh_eff)) ? sh_eff - RW'(1)
                                                             : RW'(div_quot);
                        offh_reg    <= '0;
                        kh_reg      <= '0;
                        hsum_reg[0] <= '0;
                        hsum_reg[1] <= '0;
                        hsum_reg[2] <= '0;
                        state_reg   <= ST_COL;
                    end
                end
                ST_COL: state_reg <= ST_COL_WAIT;
                ST_COL_WAIT: begin
                    if (div_stat.done) begin
                        rd_addr_reg <= AW'(row_reg) * AW'(MAX_WIDTH) + AW'(col_sel);
                        state_reg   <= ST_MEM;
                    end
                end
                ST_MEM: state_reg <= ST_ACC;
                ST_ACC: begin
                    hsum_reg[0] <= hsum_reg[0] + SUM_W'(rdata_reg[7:0]);
                    hsum_reg[1] <= hsum_reg[1] + SUM_W'(rdata_reg[15:8]);
                    hsum_reg[2] <= hsum_reg[2] + SUM_W'(rdata_reg[23:16]);
                    kh_reg      <= kh_reg + 3'd1;
                    offh_reg    <= offh_reg + NW'(hs_reg);
                    if (kh_reg + 3'd1 == hn) begin
                        ch_reg    <= '0;
                        state_reg <= ST_HAVG;
                    end else begin
                        state_reg <= ST_COL;
                    end
                end
                ST_HAVG: state_reg <= ST_HAVG_WAIT;
                ST_HAVG_WAIT: begin
                    if (div_stat.done) begin
                        vsum_reg[ch_reg] <= vsum_reg[ch_reg] + SUM_W'(div_quot);
                        if (ch_reg == 2'd2) begin
                            kv_reg   <= kv_reg + 3'd1;
                            offv_reg <= offv_reg + NW'(vs_reg);
                            ch_reg   <= '0;
                            if (kv_reg + 3'd1 == vn) begin
                                state_reg <= ST_VAVG;
                            end else begin
                                state_reg <= ST_ROW;
                            end
                        end else begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= ST_HAVG;
                        end
                    end
                end
                ST_VAVG: state_reg <= ST_VAVG_WAIT;
                ST_VAVG_WAIT: begin
                    if (div_stat.done) begin
                        res_reg[ch_reg] <= CH_W'(div_quot);
                        if (ch_reg == 2'd2) begin
                            res_last_reg <= (int'(x_reg) + 1 >= int'(dw_eff)) &&
                                            (int'(y_reg) + 1 >= int'(dh_eff));
                            res_status_reg <= 1'b0;
                            // advance the read position in raster order
                            if (int'(x_reg) + 1 >= int'(dw_eff)) begin
                                x_reg <= '0;
                                if (int'(y_reg) + 1 >= int'(dh_eff)) begin
                                    y_reg <= '0;
                                end else begin
                                    y_reg <= y_reg + RW'(1);
                                end
                            end else begin
                                x_reg <= x_reg + CW'(1);
                            end
                            state_reg <= ST_OUT;
                        end else begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= ST_VAVG;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_reg[2], res_reg[1], res_reg[0]};
                        m_tlast_reg  <= res_last_reg;
                        m_tuser_reg  <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> state_reg == ST_CFG_START)
        else $error("configuration write did not restart unit derivation");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_load_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> (lc_reg < sw_eff) && (lr_reg < sh_eff))
        else $error("load position outside source frame");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tlast && (m_tdata == '0))
        else $error("status result carries pixel data");

endmodule
